[hw/rtl/mspp_pkg.sv]
package mspp_pkg;

    localparam int POS_W         = 6;
    localparam int LEN_W         = 7;
    localparam int WEIGHT_W      = 32;
    localparam int MAX_CHARS_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic signed [WEIGHT_W-1:0] UNKNOWN_WEIGHT_RST = -32'sd1310720;
    localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};
    localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};

    typedef struct packed {
        logic                       in_range;
        logic                       tail_zero;
        logic [POS_W-1:0]           s_pos;
        logic [POS_W-1:0]           nx_pos;
        logic signed [WEIGHT_W-1:0] weight;
        logic [LEN_W-1:0]           span;
        logic                       last;
        logic [LEN_W-1:0]           len;
    } edge_t;

endpackage

[hw/rtl/mspp_front.sv]
module mspp_front #(
    parameter int MAX_CHARS = mspp_pkg::MAX_CHARS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   queue_full,
    input  logic [mspp_pkg::POS_W-1:0]             start_pos,
    input  logic [mspp_pkg::POS_W-1:0]             end_pos,
    input  logic signed [mspp_pkg::WEIGHT_W-1:0]   word_weight,
    input  logic                                   in_dictionary,
    input  logic [mspp_pkg::LEN_W-1:0]             sentence_length,
    input  logic                                   last_edge,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic signed [mspp_pkg::WEIGHT_W-1:0]   cfg_data,
    output logic                                   push,
    output mspp_pkg::edge_t                        push_word
);
    import mspp_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHARS);

    logic signed [WEIGHT_W-1:0] unknown_reg;
    logic [LEN_W-1:0]           len;
    logic [LEN_W-1:0]           s_ext;
    logic [LEN_W-1:0]           e_ext;
    logic [LEN_W-1:0]           nx;

    assign cfg_ready = 1'b1;
    assign push      = start && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unknown_reg <= UNKNOWN_WEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unknown_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (sentence_length > MAX_LEN)
        begin
            len = MAX_LEN;
        end
        else if (sentence_length == '0)
        begin
            len = LEN_W'(1);
        end
        else
        begin
            len = sentence_length;
        end
        s_ext = {1'b0, start_pos};
        e_ext = {1'b0, end_pos};
        nx    = e_ext + LEN_W'(1);

        push_word.in_range  = (s_ext < len) && (e_ext >= s_ext) && (e_ext < len);
        push_word.tail_zero = (nx >= len);
        push_word.s_pos     = start_pos;
        push_word.nx_pos    = nx[POS_W-1:0];
        push_word.weight    = in_dictionary ? word_weight : unknown_reg;
        push_word.span      = in_dictionary ? (nx - s_ext) : '0;
        push_word.last      = last_edge;
        push_word.len       = len;
    end

endmodule

[hw/rtl/mspp_queue.sv]
module mspp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mspp_pkg::edge_t push_word,
    input  logic            pop,
    output mspp_pkg::edge_t head,
    output logic            not_empty,
    output logic            full
);
    import mspp_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    edge_t          slot_reg [QUEUE_DEPTH];
    logic [QW-1:0]  wr_ptr_reg;
    logic [QW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [QW-1:0]  wr_ptr_next;
    logic [QW-1:0]  rd_ptr_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QW'(1);
        rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

[hw/rtl/mspp_back.sv]
module mspp_back #(
    parameter int MAX_CHARS = mspp_pkg::MAX_CHARS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mspp_pkg::edge_t             head,
    input  logic                        not_empty,
    output logic                        pop,
    output logic                        word_valid,
    output logic [mspp_pkg::POS_W-1:0]  word_start,
    output logic [mspp_pkg::POS_W-1:0]  word_end,
    output logic                        last_word
);
    import mspp_pkg::*;

    localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_UPD      = 2'd1;
    localparam logic [1:0] ST_EMIT_RD  = 2'd2;
    localparam logic [1:0] ST_EMIT_OUT = 2'd3;

    logic signed [WEIGHT_W-1:0] wt_mem   [MAX_CHARS];
    logic [LEN_W-1:0]           span_mem [MAX_CHARS];

    logic [1:0]                 state_reg, state_next;
    logic                       loading_reg, loading_next;
    logic [MAX_CHARS-1:0]       seen_reg, seen_next;
    logic [LEN_W-1:0]           pos_reg, pos_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    edge_t                      edge_reg;
    logic signed [WEIGHT_W-1:0] wt_nx_reg;
    logic signed [WEIGHT_W-1:0] wt_s_reg;
    logic [LEN_W-1:0]           span_rd_reg;
    logic                       word_valid_reg, word_valid_next;
    logic [POS_W-1:0]           word_start_reg, word_start_next;
    logic [POS_W-1:0]           word_end_reg, word_end_next;
    logic                       last_word_reg, last_word_next;

    logic [AW-1:0]              s_idx;
    logic [AW-1:0]              nx_idx;
    logic [AW-1:0]              pos_idx;
    logic signed [WEIGHT_W-1:0] tail;
    logic signed [WEIGHT_W-1:0] cur;
    logic signed [WEIGHT_W:0]   sum;
    logic signed [WEIGHT_W-1:0] val;
    logic                       greater;
    logic                       wr_en;
    logic                       rd_en;
    logic                       span_rd_en;
    logic [LEN_W-1:0]           span_raw;
    logic [LEN_W-1:0]           span_one;
    logic [LEN_W-1:0]           remain;
    logic [LEN_W-1:0]           span;
    logic [LEN_W-1:0]           end_full;

    assign word_valid = word_valid_reg;
    assign word_start = word_start_reg;
    assign word_end   = word_end_reg;
    assign last_word  = last_word_reg;

    assign s_idx   = edge_reg.s_pos[AW-1:0];
    assign nx_idx  = edge_reg.nx_pos[AW-1:0];
    assign pos_idx = pos_reg[AW-1:0];

    always_comb
    begin
        tail    = edge_reg.tail_zero ? '0 : (seen_reg[nx_idx] ? wt_nx_reg : W_MIN);
        cur     = seen_reg[s_idx] ? wt_s_reg : W_MIN;
        sum     = {edge_reg.weight[WEIGHT_W-1], edge_reg.weight} + {tail[WEIGHT_W-1], tail};
        if (sum[WEIGHT_W] != sum[WEIGHT_W-1])
        begin
            val = sum[WEIGHT_W] ? W_MIN : W_MAX;
        end
        else
        begin
            val = sum[WEIGHT_W-1:0];
        end
        greater = (val > cur);

        span_raw = seen_reg[pos_idx] ? span_rd_reg : '0;
        span_one = (span_raw == '0) ? LEN_W'(1) : span_raw;
        remain   = len_reg - pos_reg;
        span     = (span_one > remain) ? remain : span_one;
        end_full = pos_reg + span - LEN_W'(1);
    end

    always_comb
    begin
        state_next      = state_reg;
        loading_next    = loading_reg;
        seen_next       = seen_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        word_valid_next = 1'b0;
        word_start_next = word_start_reg;
        word_end_next   = word_end_reg;
        last_word_next  = last_word_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        span_rd_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    pop   = 1'b1;
                    rd_en = 1'b1;
                    if (!loading_reg)
                    begin
                        seen_next    = '0;
                        loading_next = 1'b1;
                    end
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (edge_reg.in_range)
                begin
                    wr_en            = greater || !seen_reg[s_idx];
                    seen_next[s_idx] = 1'b1;
                end
                if (edge_reg.last)
                begin
                    pos_next   = '0;
                    len_next   = edge_reg.len;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                span_rd_en = 1'b1;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                word_valid_next = 1'b1;
                word_start_next = pos_reg[POS_W-1:0];
                word_end_next   = end_full[POS_W-1:0];
                last_word_next  = (span == remain);
                pos_next        = pos_reg + span;
                if (span == remain)
                begin
                    loading_next = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            edge_reg <= head;
        end
        if (rd_en)
        begin
            wt_nx_reg <= wt_mem[head.nx_pos[AW-1:0]];
            wt_s_reg  <= wt_mem[head.s_pos[AW-1:0]];
        end
        if (span_rd_en)
        begin
            span_rd_reg <= span_mem[pos_idx];
        end
        if (wr_en)
        begin
            wt_mem[s_idx]   <= greater ? val : W_MIN;
            span_mem[s_idx] <= greater ? edge_reg.span : '0;
        end
        word_start_reg <= word_start_next;
        word_end_reg   <= word_end_next;
        last_word_reg  <= last_word_next;
        pos_reg        <= pos_next;
        len_reg        <= len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            loading_reg    <= 1'b0;
            seen_reg       <= '0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loading_reg    <= loading_next;
            seen_reg       <= seen_next;
            word_valid_reg <= word_valid_next;
        end
    end

endmodule

[hw/rtl/max_probability_segment_path_top.sv]
// Channel   Handshake                 Payload
// edge in   start / busy              start_pos end_pos word_weight in_dictionary
//                                     sentence_length last_edge
// config    cfg_valid / cfg_ready     cfg_data (unknown-word weight)
// word out  word_valid (strobe)       word_start word_end last_word
//
// In the update unit an edge goes through the weight memory read, then the
// saturating add, compare and write back.
// After a last edge, each emitted word needs a span memory read and then its output step.
// A two-entry queue takes edges while the update unit or the word walk works;
// busy rises only when that queue is full.
// rst_n clears control and the seen bits and sets the config register to its default unknown-word weight at once.
// Each word shows for one cycle; the receiver cannot stall.
module max_probability_segment_path_top #(
    parameter int MAX_CHARS = mspp_pkg::MAX_CHARS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [mspp_pkg::POS_W-1:0]             start_pos,
    input  logic [mspp_pkg::POS_W-1:0]             end_pos,
    input  logic signed [mspp_pkg::WEIGHT_W-1:0]   word_weight,
    input  logic                                   in_dictionary,
    input  logic [mspp_pkg::LEN_W-1:0]             sentence_length,
    input  logic                                   last_edge,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic signed [mspp_pkg::WEIGHT_W-1:0]   cfg_data,
    output logic                                   word_valid,
    output logic [mspp_pkg::POS_W-1:0]             word_start,
    output logic [mspp_pkg::POS_W-1:0]             word_end,
    output logic                                   last_word
);
    import mspp_pkg::*;

    logic  push;
    logic  pop;
    logic  not_empty;
    logic  queue_full;
    edge_t push_word;
    edge_t head;

    assign busy = queue_full;

    mspp_front #(
        .MAX_CHARS(MAX_CHARS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .queue_full     (queue_full),
        .start_pos      (start_pos),
        .end_pos        (end_pos),
        .word_weight    (word_weight),
        .in_dictionary  (in_dictionary),
        .sentence_length(sentence_length),
        .last_edge      (last_edge),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .push           (push),
        .push_word      (push_word)
    );

    mspp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_word(push_word),
        .pop      (pop),
        .head     (head),
        .not_empty(not_empty),
        .full     (queue_full)
    );

    mspp_back #(
        .MAX_CHARS(MAX_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .word_valid(word_valid),
        .word_start(word_start),
        .word_end  (word_end),
        .last_word (last_word)
    );

endmodule
